[rtl/assert_macros.svh]
// Assertion helpers for the RTL of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge while out of reset.
`define ASSERT_CLK(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check an implication on every rising clock edge while out of reset.
`define ASSERT_IMPLY(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

`endif

[rtl/isotp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package isotp_pkg;

    localparam int unsigned MSG_LEN_W   = 12;
    localparam int unsigned PAYLOAD_MAX = 7;
    localparam int unsigned FF_PAYLOAD  = 6;
    localparam int unsigned FRAME_BYTES = 8;

    localparam logic [MSG_LEN_W-1:0] MAX_MSG_LEN = 12'd4095;
    localparam logic [7:0] PAD_BYTE = 8'h55;
    localparam logic [7:0] PCI_FF   = 8'h10;
    localparam logic [7:0] PCI_CF   = 8'h20;
    localparam logic [3:0] SEQ_INIT = 4'd1;

    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_FIRST  = 2'd1,
        KIND_CONSEC = 2'd2
    } frame_kind_t;

    typedef logic [7:0] byte_t;

endpackage

`default_nettype wire

[rtl/isotp_tx_segmenter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Transmit segmenter for ISO 15765-2 transport: takes one message byte per beat and
// emits 8-byte CAN frames (single, first or consecutive, padded with 0x55), with tlast
// on the frame that ends the message and an error beat for a zero length. It accepts
// one byte every cycle; a byte passes an input register and the framing logic and its
// frame is registered in the output register. While a frame waits at the output, the
// byte in the input register holds and the input stalls until the frame is taken.
`include "assert_macros.svh"

module isotp_tx_segmenter_unit
    import isotp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // data_byte[7:0], msg_length[19:8], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // frame_byte0[7:0] .. frame_byte7[63:56]
    output logic [2:0]       m_axis_tuser,   // frame_kind[1:0], status[2]
    output logic             m_axis_tlast    // message_done
);

    logic                 in_valid_reg, in_valid_next;
    byte_t                in_data_reg;
    logic [MSG_LEN_W-1:0] in_len_reg;

    logic [MSG_LEN_W-1:0] pos_reg, pos_next;
    logic [MSG_LEN_W-1:0] latched_reg, latched_next;
    logic [2:0]           fill_reg, fill_next;
    logic [3:0]           seq_reg, seq_next;
    byte_t                payload_reg [PAYLOAD_MAX];

    logic                 out_valid_reg, out_valid_next;
    logic [63:0]          out_data_reg, out_data_next;
    logic [2:0]           out_user_reg, out_user_next;
    logic                 out_last_reg, out_last_next;

    logic                 advance;
    logic                 idle;
    logic                 invalid;
    logic [MSG_LEN_W-1:0] len;
    logic [MSG_LEN_W-1:0] pos1;
    logic [2:0]           fill;
    logic [2:0]           fill1;
    logic [2:0]           cap;
    logic [3:0]           seq;
    logic                 last;
    logic                 emit;
    frame_kind_t          kind;
    byte_t                view [PAYLOAD_MAX];
    byte_t                frame [FRAME_BYTES];

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_valid_next = s_axis_tvalid ? 1'b1 : (in_valid_reg && !advance);

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata[7:0];
            in_len_reg  <= s_axis_tdata[19:8];
        end
    end

    always_comb
    begin
        idle    = (pos_reg == '0);
        invalid = idle && ((in_len_reg == '0) || (in_len_reg > MAX_MSG_LEN));
        len     = idle ? in_len_reg : latched_reg;
        fill    = idle ? 3'd0 : fill_reg;
        seq     = idle ? SEQ_INIT : seq_reg;
        fill1   = fill + 3'd1;
        pos1    = pos_reg + 12'd1;
        if (len <= 12'(PAYLOAD_MAX))
        begin
            kind = KIND_SINGLE;
            cap  = len[2:0];
        end
        else if (pos1 <= 12'(FF_PAYLOAD))
        begin
            kind = KIND_FIRST;
            cap  = 3'(FF_PAYLOAD);
        end
        else
        begin
            kind = KIND_CONSEC;
            cap  = 3'(PAYLOAD_MAX);
        end
        last = (pos1 == len);
        emit = (fill1 == cap) || last;
        for (int i = 0; i < PAYLOAD_MAX; i++)
        begin
            view[i] = (3'(i) == fill) ? in_data_reg : payload_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame[i] = PAD_BYTE;
        end
        unique case (kind)
            KIND_SINGLE:
            begin
                frame[0] = {4'h0, len[3:0]};
                for (int i = 0; i < PAYLOAD_MAX; i++)
                begin
                    if (3'(i) < fill1)
                        frame[i+1] = view[i];
                end
            end
            KIND_FIRST:
            begin
                frame[0] = PCI_FF | {4'h0, len[11:8]};
                frame[1] = len[7:0];
                for (int i = 0; i < FF_PAYLOAD; i++)
                begin
                    if (3'(i) < fill1)
                        frame[i+2] = view[i];
                end
            end
            KIND_CONSEC:
            begin
                frame[0] = PCI_CF | {4'h0, seq};
                for (int i = 0; i < PAYLOAD_MAX; i++)
                begin
                    if (3'(i) < fill1)
                        frame[i+1] = view[i];
                end
            end
            default:
            begin
                frame[0] = PAD_BYTE;
            end
        endcase
    end

    always_comb
    begin
        pos_next       = pos_reg;
        latched_next   = latched_reg;
        fill_next      = fill_reg;
        seq_next       = seq_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            if (invalid)
            begin
                out_valid_next = 1'b1;
                out_data_next  = '0;
                out_user_next  = {1'b1, KIND_SINGLE};
                out_last_next  = 1'b1;
            end
            else
            begin
                latched_next = len;
                fill_next    = emit ? 3'd0 : fill1;
                pos_next     = last ? '0 : pos1;
                if (last)
                    seq_next = SEQ_INIT;
                else if (emit && (kind == KIND_CONSEC))
                    seq_next = seq + 4'd1;
                else
                    seq_next = seq;
                out_valid_next = emit;
                for (int i = 0; i < FRAME_BYTES; i++)
                begin
                    out_data_next[i*8 +: 8] = frame[i];
                end
                out_user_next = {1'b0, kind};
                out_last_next = last;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && !invalid)
        begin
            for (int i = 0; i < PAYLOAD_MAX; i++)
            begin
                if (3'(i) == fill)
                    payload_reg[i] <= in_data_reg;
            end
        end
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            latched_reg   <= '0;
            fill_reg      <= '0;
            seq_reg       <= SEQ_INIT;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            latched_reg   <= latched_next;
            fill_reg      <= fill_next;
            seq_reg       <= seq_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;

    `ASSERT_IMPLY(a_busy_has_length, pos_reg != '0, latched_reg != '0)
    `ASSERT_IMPLY(a_pos_below_length, pos_reg != '0, pos_reg < latched_reg)
    `ASSERT_IMPLY(a_idle_seq_init, pos_reg == '0, seq_reg == SEQ_INIT)
    `ASSERT_CLK(a_fill_never_full, fill_reg != 3'd7)
    `ASSERT_IMPLY(a_error_ends_msg, m_axis_tvalid && m_axis_tuser[2], m_axis_tlast)

endmodule

`default_nettype wire
